// ===== sv/sma_pkg.sv =====
// Shared types and constants for the stack machine ALU: beat structs, word
// and error codes, cell shift controls and the sequencer state encoding.
// No dependencies.
`default_nettype none

package sma_pkg;

  localparam int DATA_W = 32;

  localparam logic [2:0] WORD_PUSH = 3'd0;
  localparam logic [2:0] WORD_DUP  = 3'd1;
  localparam logic [2:0] WORD_DROP = 3'd2;
  localparam logic [2:0] WORD_ADD  = 3'd3;
  localparam logic [2:0] WORD_SUB  = 3'd4;
  localparam logic [2:0] WORD_MUL  = 3'd5;
  localparam logic [2:0] WORD_DIV  = 3'd6;
  localparam logic [2:0] WORD_MOD  = 3'd7;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_UNDER = 2'd1;
  localparam logic [1:0] ERR_OVER  = 2'd2;
  localparam logic [1:0] ERR_DIVZ  = 2'd3;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] literal_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [6:0]               stack_depth;
    logic [1:0]               error_code;
  } out_beat_t;

  // HOLD keeps the entry, SHIFT_IN takes the entry from the cell nearer the
  // top, SHIFT_OUT takes the entry from the cell further down.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_IN,
    CELL_SHIFT_OUT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op_head;
    cell_op_t op_body;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_DONE
  } sma_state_t;

endpackage

`default_nettype wire

// ===== sv/sma_cell.sv =====
// One stack entry of the shift-register stack. Depends on sma_pkg for the
// cell control struct.
`default_nettype none

module sma_cell
  import sma_pkg::*;
#(
  parameter bit IS_HEAD = 1'b0
) (
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [DATA_W-1:0] prev_data,
  input  wire logic [DATA_W-1:0] next_data,
  output logic      [DATA_W-1:0] data_r
);

  cell_op_t          op;
  logic [DATA_W-1:0] data_nxt;

  assign op = IS_HEAD ? ctl.op_head : ctl.op_body;

  always_comb begin
    case (op)
      CELL_SHIFT_IN:  data_nxt = prev_data;
      CELL_SHIFT_OUT: data_nxt = next_data;
      default:        data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/sma_div.sv =====
// Iterative signed divider, one quotient bit per cycle on magnitudes, with
// sign fix-up on the outputs. Depends on sma_pkg for the data width.
`default_nettype none

module sma_div
  import sma_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic      [DATA_W-1:0] quotient,
  output logic      [DATA_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] q_r, q_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic              neg_q_r, neg_q_nxt;
  logic              neg_r_r, neg_r_nxt;
  logic [DATA_W:0]   trial;

  assign trial = {rem_r, q_r[DATA_W-1]} - {1'b0, dvs_r};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      q_nxt     = dividend[DATA_W-1] ? (-dividend) : dividend;
      dvs_nxt   = divisor[DATA_W-1] ? (-divisor) : divisor;
      rem_nxt   = '0;
      neg_q_nxt = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      neg_r_nxt = dividend[DATA_W-1];
    end else if (busy_r) begin
      if (!trial[DATA_W]) begin
        rem_nxt = trial[DATA_W-1:0];
        q_nxt   = {q_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DATA_W-2:0], q_r[DATA_W-1]};
        q_nxt   = {q_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r   <= cnt_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
  end

  assign done      = done_r;
  assign quotient  = neg_q_r ? (-q_r) : q_r;
  assign remainder = neg_r_r ? (-rem_r) : rem_r;

endmodule

`default_nettype wire

// ===== sv/stack_machine_alu_unit.sv =====
// Top level of the stack machine ALU: sequencer, arithmetic, output register
// and the row of stack cells. Depends on sma_pkg, sma_cell and sma_div.
//
// Usage: each input beat carries one word (push, dup, drop, add, sub, mul,
// div, mod) and, for push, a literal. Every input beat yields exactly one
// output beat holding the top of stack after the word (zero when empty),
// the stack depth and an error code. A word that fails leaves the stack as
// it was. The stack is a chain of cells: cell 0 holds the top, and every
// push or pop moves all entries one cell in the same cycle.
// Timing: an input beat is accepted only while the block is idle. The output
// beat for push, dup, drop, add, sub and any failing word is registered from
// the execute state; mul passes through a done state first (the product is
// registered), and div and mod run the 32 steps of the one-bit-per-cycle
// divider before the done state. The input is ready again in the same cycle
// that the output beat turns valid.
// A finished output beat waits in the output register while the next word
// is accepted and executed; if the receiver stalls, the block holds the
// following result, and with it the input, until the output register frees.
// Reset empties the stack and drops any pending output beat; stack contents
// themselves are not cleared, since only entries below the depth are read.
`default_nettype none

module stack_machine_alu_unit
  import sma_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  sma_state_t        state_r, state_nxt;
  in_beat_t          req_r;
  logic [CW-1:0]     depth_r, depth_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_data_r, out_data_nxt;

  logic [DATA_W-1:0] cell_q [STACK_DEPTH];
  cell_ctl_t         ctl;
  logic [DATA_W-1:0] head_data;

  logic [DATA_W-1:0] top_q, sec_q, top_or_zero, sec_or_zero;
  logic [DATA_W-1:0] sum, diff;
  logic [DATA_W-1:0] product;
  logic [1:0]        err;
  logic              slot_free;
  logic              div_start, div_done;
  logic [DATA_W-1:0] div_q, div_rem;

  logic [CW-1:0]     depth_inc, depth_dec;
  logic [CW+6:0]     depth_inc_w, depth_dec_w, depth_cur_w;

  // The row of stack cells; cell 0 is the top of stack.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] prev_d, next_d;
    if (i == 0) begin : g_first
      assign prev_d = head_data;
    end else begin : g_mid
      assign prev_d = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_inner
      assign next_d = cell_q[i+1];
    end
    sma_cell #(
      .IS_HEAD (i == 0)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .prev_data (prev_d),
      .next_data (next_d),
      .data_r    (cell_q[i])
    );
  end

  sma_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (sec_q),
    .divisor   (top_q),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign top_q       = cell_q[0];
  assign sec_q       = cell_q[1];
  assign top_or_zero = (depth_r != '0) ? top_q : '0;
  assign sec_or_zero = (depth_r > CW'(1)) ? sec_q : '0;
  assign sum         = sec_q + top_q;
  assign diff        = sec_q - top_q;
  // Only the low word of the product is kept, so a 32 by 32 multiply suffices.
  assign product     = sec_q * top_q;

  assign depth_inc   = depth_r + CW'(1);
  assign depth_dec   = depth_r - CW'(1);
  // The reported depth is the low seven bits of the count.
  assign depth_inc_w = {7'd0, depth_inc};
  assign depth_dec_w = {7'd0, depth_dec};
  assign depth_cur_w = {7'd0, depth_r};

  assign slot_free = !out_valid_r || out_ready;

  // Error check of the word held in req_r; underflow wins over divide by zero.
  always_comb begin
    err = ERR_OK;
    case (req_r.req_type)
      WORD_PUSH: begin
        if (depth_r == CW'(STACK_DEPTH)) err = ERR_OVER;
      end
      WORD_DUP: begin
        if (depth_r == '0) err = ERR_UNDER;
        else if (depth_r == CW'(STACK_DEPTH)) err = ERR_OVER;
      end
      WORD_DROP: begin
        if (depth_r == '0) err = ERR_UNDER;
      end
      WORD_DIV, WORD_MOD: begin
        if (depth_r < CW'(2)) err = ERR_UNDER;
        else if (top_q == '0) err = ERR_DIVZ;
      end
      default: begin
        if (depth_r < CW'(2)) err = ERR_UNDER;
      end
    endcase
  end

  // Sequencer: next state, cell shifts and the output beat.
  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    res_nxt       = res_r;
    ctl           = '{op_head: CELL_HOLD, op_body: CELL_HOLD};
    head_data     = req_r.literal_value;
    div_start     = 1'b0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    in_ready      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = S_EXEC;
      end

      S_EXEC: begin
        if (err != ERR_OK) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{top_value: top_or_zero, stack_depth: depth_cur_w[6:0],
                              error_code: err};
            state_nxt     = S_IDLE;
          end
        end else begin
          case (req_r.req_type)
            WORD_MUL: begin
              res_nxt   = product[DATA_W-1:0];
              state_nxt = S_DONE;
            end
            WORD_DIV, WORD_MOD: begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
            default: begin
              if (slot_free) begin
                out_valid_nxt = 1'b1;
                state_nxt     = S_IDLE;
                case (req_r.req_type)
                  WORD_PUSH: begin
                    ctl          = '{op_head: CELL_SHIFT_IN, op_body: CELL_SHIFT_IN};
                    depth_nxt    = depth_inc;
                    out_data_nxt = '{top_value: req_r.literal_value,
                                     stack_depth: depth_inc_w[6:0], error_code: ERR_OK};
                  end
                  WORD_DUP: begin
                    ctl          = '{op_head: CELL_HOLD, op_body: CELL_SHIFT_IN};
                    depth_nxt    = depth_inc;
                    out_data_nxt = '{top_value: top_q, stack_depth: depth_inc_w[6:0],
                                     error_code: ERR_OK};
                  end
                  WORD_DROP: begin
                    ctl          = '{op_head: CELL_SHIFT_OUT, op_body: CELL_SHIFT_OUT};
                    depth_nxt    = depth_dec;
                    out_data_nxt = '{top_value: sec_or_zero, stack_depth: depth_dec_w[6:0],
                                     error_code: ERR_OK};
                  end
                  default: begin
                    // Add or subtract: the result replaces the two operands.
                    head_data    = (req_r.req_type == WORD_ADD) ? sum : diff;
                    ctl          = '{op_head: CELL_SHIFT_IN, op_body: CELL_SHIFT_OUT};
                    depth_nxt    = depth_dec;
                    out_data_nxt = '{top_value: head_data, stack_depth: depth_dec_w[6:0],
                                     error_code: ERR_OK};
                  end
                endcase
              end
            end
          endcase
        end
      end

      S_DIV: begin
        if (div_done) begin
          res_nxt   = (req_r.req_type == WORD_MOD) ? div_rem : div_q;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Commit a registered multiply or divide result.
        head_data = res_r;
        if (slot_free) begin
          ctl           = '{op_head: CELL_SHIFT_IN, op_body: CELL_SHIFT_OUT};
          depth_nxt     = depth_dec;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{top_value: res_r, stack_depth: depth_dec_w[6:0],
                            error_code: ERR_OK};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_valid && in_ready) req_r <= in_data;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
